// ===== hw/rtl/mips_subset_execute_with_scoreboard_assert.svh =====
// assertion helpers included by the execute unit rtl file
`ifndef MIPS_SUBSET_EXECUTE_WITH_SCOREBOARD_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_WITH_SCOREBOARD_ASSERT_SVH

// consequent checked in the same cycle
`define MSE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define MSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mse_pkg.sv =====
package mse_pkg;

    localparam int NREGS  = 32;
    localparam int REG_W  = 5;
    localparam int CORE_W = 2;
    localparam int DATA_W = 32;
    localparam int FPC_W  = 17;
    localparam int IMM_W  = 18;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 128;

    localparam logic KIND_INSTR = 1'b0;
    localparam logic KIND_LOAD  = 1'b1;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_SLT   = 4'd3,
        OP_ADDI  = 4'd4,
        OP_BEQ   = 4'd5,
        OP_BNE   = 4'd6,
        OP_J     = 4'd7,
        OP_LW    = 4'd8,
        OP_SW    = 4'd9,
        OP_LABEL = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_READ  = 2'd1,
        MEM_WRITE = 2'd2
    } mem_req_t;

    // declared msb first, so core sits in the lowest bits of tdata
    typedef struct packed {
        logic [6:0]              pad;
        logic [DATA_W-1:0]       load_data;
        logic [FPC_W-1:0]        target;
        logic signed [IMM_W-1:0] immediate;
        logic                    use_immediate;
        logic [REG_W-1:0]        third_reg;
        logic [REG_W-1:0]        second_reg;
        logic [REG_W-1:0]        first_reg;
        logic [3:0]              opcode;
        logic [CORE_W-1:0]       core;
    } item_t;

    // declared msb first, so stalled sits in bit 0
    typedef struct packed {
        logic [5:0]        pad;
        logic [DATA_W-1:0] store_data;
        logic [DATA_W-1:0] mem_address;
        mem_req_t          mem_request;
        logic [DATA_W-1:0] written_value;
        logic [REG_W-1:0]  written_reg;
        logic              wrote;
        logic [FPC_W-1:0]  next_pc;
        logic              stalled;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [CORE_W-1:0] core;
        logic [REG_W-1:0]  regnum;
        logic [DATA_W-1:0] data;
    } rf_wr_t;

endpackage

// ===== hw/rtl/mse_regfile.sv =====
module mse_regfile
    import mse_pkg::*;
#(
    parameter int CORES = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [CORE_W-1:0] rd_core,
    input  logic [REG_W-1:0]  rd_reg_a,
    input  logic [REG_W-1:0]  rd_reg_b,
    input  rf_wr_t            wr,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    localparam int DEPTH = CORES * NREGS;
    localparam int IDX_W = $clog2(DEPTH);

    logic [DATA_W-1:0] rf_mem_reg [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic              byp_vld_reg;
    logic [IDX_W-1:0]  byp_idx_reg;
    logic [DATA_W-1:0] byp_data_reg;
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;
    logic              vld_a_reg;
    logic              vld_b_reg;
    logic [IDX_W-1:0]  ridx_a_reg;
    logic [IDX_W-1:0]  ridx_b_reg;

    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] idx_w;

    assign idx_a = IDX_W'({{IDX_W{1'b0}}, rd_core, rd_reg_a});
    assign idx_b = IDX_W'({{IDX_W{1'b0}}, rd_core, rd_reg_b});
    assign idx_w = IDX_W'({{IDX_W{1'b0}}, wr.core, wr.regnum});

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            rf_mem_reg[idx_w] <= wr.data;
            byp_idx_reg       <= idx_w;
            byp_data_reg      <= wr.data;
        end
        if (rd_en) begin
            rd_a_reg   <= rf_mem_reg[idx_a];
            rd_b_reg   <= rf_mem_reg[idx_b];
            vld_a_reg  <= valid_reg[idx_a];
            vld_b_reg  <= valid_reg[idx_b];
            ridx_a_reg <= idx_a;
            ridx_b_reg <= idx_b;
        end
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            byp_vld_reg <= 1'b0;
        end else if (wr.en) begin
            valid_reg[idx_w] <= 1'b1;
            byp_vld_reg      <= 1'b1;
        end
    end

    // the read is taken at the same edge as the latest write, so forward it
    always_comb begin
        if (byp_vld_reg && byp_idx_reg == ridx_a_reg) begin
            rd_data_a = byp_data_reg;
        end else begin
            rd_data_a = vld_a_reg ? rd_a_reg : '0;
        end
        if (byp_vld_reg && byp_idx_reg == ridx_b_reg) begin
            rd_data_b = byp_data_reg;
        end else begin
            rd_data_b = vld_b_reg ? rd_b_reg : '0;
        end
    end

endmodule

// ===== hw/rtl/mips_subset_execute_with_scoreboard.sv =====
// Integer execute unit for a small MIPS subset shared by several cores.
// Each core owns 32 registers, a program counter and a load-pending flag
// per register.
// Input channel s_axis: one instruction or load-return item per handshake;
// tuser is the kind (0 instruction, 1 load data coming back from memory).
// Output channel m_axis: exactly one result item per input item, in order:
// stall flag, new pc, register write and memory request.
// Pipeline: two register stages (execute register, result register); an
// accepted item moves on into the result register once that register is free.
// Throughput: one item per cycle while m_axis_tready stays high; the register
// file memory is read at the accepting edge (two read ports) and written when
// the item retires into the result register, with the last write forwarded.
// Reset (aresetn low, synchronous) empties both stages, clears all
// pending flags, zeroes the pcs and marks every register as zero.
// When the receiver holds m_axis_tready low the result register keeps its
// item, one more item is taken into the execute register and s_axis_tready
// then drops until the result is taken.
`include "mips_subset_execute_with_scoreboard_assert.svh"

module mips_subset_execute_with_scoreboard
    import mse_pkg::*;
#(
    parameter int CORES    = 4,
    parameter int PC_WIDTH = 17
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // core, opcode, first_reg, second_reg, third_reg, use_immediate,
    // immediate, target, load_data, zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // kind
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // stalled, next_pc, wrote, written_reg, written_value, mem_request,
    // mem_address, store_data, zero fill
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int DEPTH  = CORES * NREGS;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CIDX_W = (CORES > 1) ? $clog2(CORES) : 1;

    logic              s1_valid_reg;
    item_t             s1_item_reg;
    logic              s1_kind_reg;
    logic              m_valid_reg;
    result_t           m_res_reg;
    logic [PC_WIDTH-1:0] pc_reg [CORES];
    logic [DEPTH-1:0]  pending_reg;

    item_t             in_item;
    op_t               in_op;
    logic              in_sel_first;
    logic              out_free;
    logic              s_fire;
    logic              s1_fire;

    op_t               op;
    logic              core_ok;
    logic [IDX_W-1:0]  pidx1;
    logic [IDX_W-1:0]  pidx2;
    logic [IDX_W-1:0]  pidx3;
    logic              chk1;
    logic              chk2;
    logic              chk3;
    logic              stall;
    logic [PC_WIDTH-1:0] pc_cur;
    logic [PC_WIDTH-1:0] pc_tgt;
    logic [PC_WIDTH-1:0] pc_next;
    logic              pc_we;
    logic              set_pd;
    logic              clr_pd;
    logic [DATA_W-1:0] ra;
    logic [DATA_W-1:0] rb;
    logic [DATA_W-1:0] imm_ext;
    logic [DATA_W-1:0] b_op;
    logic [DATA_W-1:0] alu_res;
    logic              alu_en;
    rf_wr_t            rf_wr;
    result_t           res_next;

    // handshake and stage control
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s1_fire       = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_res_reg;

    // second read port serves the compared or stored register for branches and sw
    assign in_item = item_t'(s_axis_tdata);
    assign in_op   = op_t'(in_item.opcode);
    assign in_sel_first = (in_op == OP_BEQ) || (in_op == OP_BNE) || (in_op == OP_SW);

    mse_regfile #(
        .CORES(CORES)
    ) u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_fire),
        .rd_core   (in_item.core),
        .rd_reg_a  (in_item.second_reg),
        .rd_reg_b  (in_sel_first ? in_item.first_reg : in_item.third_reg),
        .wr        (rf_wr),
        .rd_data_a (ra),
        .rd_data_b (rb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_item_reg <= in_item;
            s1_kind_reg <= s_axis_tuser;
        end
        if (s1_fire) begin
            m_res_reg <= res_next;
        end
    end

    // execute stage
    assign op      = op_t'(s1_item_reg.opcode);
    assign core_ok = int'(s1_item_reg.core) < CORES;
    assign pidx1   = IDX_W'({{IDX_W{1'b0}}, s1_item_reg.core, s1_item_reg.first_reg});
    assign pidx2   = IDX_W'({{IDX_W{1'b0}}, s1_item_reg.core, s1_item_reg.second_reg});
    assign pidx3   = IDX_W'({{IDX_W{1'b0}}, s1_item_reg.core, s1_item_reg.third_reg});
    assign pc_cur  = core_ok ? pc_reg[CIDX_W'(s1_item_reg.core)] : '0;
    assign pc_tgt  = PC_WIDTH'(s1_item_reg.target);
    assign imm_ext = {{(DATA_W-IMM_W){s1_item_reg.immediate[IMM_W-1]}},
                      s1_item_reg.immediate};
    assign b_op    = s1_item_reg.use_immediate ? imm_ext : rb;

    // scoreboard check
    always_comb begin
        chk1 = 1'b0;
        chk2 = 1'b0;
        chk3 = 1'b0;
        unique case (op)
            OP_ADD, OP_SUB, OP_MUL, OP_SLT: begin
                chk1 = 1'b1;
                chk2 = 1'b1;
                chk3 = !s1_item_reg.use_immediate;
            end
            OP_ADDI, OP_LW, OP_SW: begin
                chk1 = 1'b1;
                chk2 = 1'b1;
            end
            OP_BEQ, OP_BNE: begin
                chk1 = 1'b1;
                chk2 = !s1_item_reg.use_immediate;
            end
            default: begin
            end
        endcase
    end

    assign stall = (chk1 && pending_reg[pidx1]) || (chk2 && pending_reg[pidx2]) ||
                   (chk3 && pending_reg[pidx3]);

    always_comb begin
        alu_res = '0;
        alu_en  = 1'b0;
        unique case (op)
            OP_ADD: begin
                alu_res = ra + b_op;
                alu_en  = 1'b1;
            end
            OP_SUB: begin
                alu_res = ra - b_op;
                alu_en  = 1'b1;
            end
            OP_MUL: begin
                alu_res = ra * b_op;
                alu_en  = 1'b1;
            end
            OP_SLT: begin
                alu_res = {{(DATA_W-1){1'b0}}, ($signed(ra) < $signed(b_op))};
                alu_en  = 1'b1;
            end
            OP_ADDI: begin
                alu_res = ra + imm_ext;
                alu_en  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res_next     = '0;
        rf_wr        = '0;
        rf_wr.core   = s1_item_reg.core;
        rf_wr.regnum = s1_item_reg.first_reg;
        pc_next      = pc_cur;
        pc_we        = 1'b0;
        set_pd       = 1'b0;
        clr_pd       = 1'b0;
        if (core_ok) begin
            if (s1_kind_reg == KIND_LOAD) begin
                clr_pd = 1'b1;
                if (s1_item_reg.first_reg != '0) begin
                    rf_wr.en = 1'b1;
                    rf_wr.data = s1_item_reg.load_data;
                end
            end else if (stall) begin
                res_next.stalled = 1'b1;
            end else begin
                pc_we   = 1'b1;
                pc_next = pc_cur + PC_WIDTH'(1);
                unique case (op)
                    OP_BEQ, OP_BNE: begin
                        // rb holds first_reg, ra holds second_reg here
                        if ((op == OP_BEQ) ==
                            (rb == (s1_item_reg.use_immediate ? imm_ext : ra))) begin
                            pc_next = pc_tgt;
                        end
                    end
                    OP_J: begin
                        pc_next = pc_tgt;
                    end
                    OP_LW: begin
                        set_pd = 1'b1;
                        res_next.mem_request = MEM_READ;
                        res_next.mem_address = imm_ext + ra;
                    end
                    OP_SW: begin
                        res_next.mem_request = MEM_WRITE;
                        res_next.mem_address = imm_ext + ra;
                        res_next.store_data  = rb;
                    end
                    default: begin
                    end
                endcase
                if (alu_en && s1_item_reg.first_reg != '0) begin
                    rf_wr.en = 1'b1;
                    rf_wr.data = alu_res;
                end
            end
            res_next.next_pc = FPC_W'(pc_next);
        end
        if (!s1_fire) begin
            rf_wr.en = 1'b0;
        end
        res_next.wrote         = rf_wr.en;
        res_next.written_reg   = rf_wr.en ? rf_wr.regnum : '0;
        res_next.written_value = rf_wr.en ? rf_wr.data : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            for (int i = 0; i < CORES; i++) begin
                pc_reg[i] <= '0;
            end
        end else if (s1_fire) begin
            if (set_pd) begin
                pending_reg[pidx1] <= 1'b1;
            end else if (clr_pd) begin
                pending_reg[pidx1] <= 1'b0;
            end
            if (pc_we) begin
                pc_reg[CIDX_W'(s1_item_reg.core)] <= pc_next;
            end
        end
    end

    `MSE_ASSERT_SAME(a_stall_quiet, m_valid_reg && m_res_reg.stalled,
        !m_res_reg.wrote && m_res_reg.mem_request == MEM_NONE, "stalled item had effects")
    `MSE_ASSERT_SAME(a_zero_reg_kept, m_valid_reg && m_res_reg.wrote,
        m_res_reg.written_reg != '0, "register zero written")
    `MSE_ASSERT_SAME(a_req_code, m_valid_reg,
        m_res_reg.mem_request == MEM_NONE || m_res_reg.mem_request == MEM_READ ||
        m_res_reg.mem_request == MEM_WRITE, "bad memory request code")
    `MSE_ASSERT_NEXT(a_lw_pending, s1_fire && set_pd,
        pending_reg[$past(pidx1)], "load did not mark its register pending")
    `MSE_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !out_free,
        s1_valid_reg, "execute stage item lost while output stalled")

endmodule

// ===== test/tb_mips_subset_execute_with_scoreboard.sv =====
`timescale 1ns / 1ps

module tb_mips_subset_execute_with_scoreboard;
    import mse_pkg::*;

    localparam int CORES_N = 4;
    localparam int LIMIT = 200000;
    localparam int RANDOM_ITEMS = 950;
    localparam logic [3:0] OP_UNUSED_TOP = 4'd15;

    typedef struct {
        logic    kind;
        item_t   it;
        bit      exact;
        result_t want;
    } stim_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // core, opcode, first_reg, second_reg, third_reg, use_immediate,
    // immediate, target, load_data, zero fill
    logic [S_TDATA_W-1:0] s_axis_tdata;
    // kind
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // stalled, next_pc, wrote, written_reg, written_value, mem_request,
    // mem_address, store_data, zero fill
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // shadow of the architectural state, indexed by {core, reg}
    logic [31:0] gpr [128];
    logic        busy [128];
    logic [16:0] pc_of [CORES_N];

    stim_t   items[$];
    stim_t   dir_rows[25];
    result_t pending_results[$];

    int n_accepted = 0;
    int n_results = 0;
    int errors = 0;
    int cycles = 0;
    int send_idle = 25;
    int recv_idle = 51;

    always #2 aclk = ~aclk;

    mips_subset_execute_with_scoreboard DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic stim_t make_item(input logic kind, input logic [1:0] core,
                                        input logic [3:0] op, input logic [4:0] r1,
                                        input logic [4:0] r2, input logic [4:0] r3,
                                        input logic ui, input logic [17:0] imm,
                                        input logic [16:0] tgt, input logic [31:0] ld);
        stim_t s;
        s.kind = kind;
        s.it = '0;
        s.it.core = core;
        s.it.opcode = op;
        s.it.first_reg = r1;
        s.it.second_reg = r2;
        s.it.third_reg = r3;
        s.it.use_immediate = ui;
        s.it.immediate = imm;
        s.it.target = tgt;
        s.it.load_data = ld;
        s.exact = 1'b0;
        s.want = '0;
        return s;
    endfunction

    function automatic result_t make_result(input logic st, input logic [16:0] npc,
                                            input logic wr, input logic [4:0] wreg,
                                            input logic [31:0] wval, input mem_req_t req,
                                            input logic [31:0] addr, input logic [31:0] sd);
        result_t r;
        r = '0;
        r.stalled = st;
        r.next_pc = npc;
        r.wrote = wr;
        r.written_reg = wreg;
        r.written_value = wval;
        r.mem_request = req;
        r.mem_address = addr;
        r.store_data = sd;
        return r;
    endfunction

    // registers 0..7 most of the time so hazards on pending loads happen often
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(3) != 0) begin
            return 5'($urandom_range(7));
        end
        return 5'($urandom_range(31));
    endfunction

    // executes one item against the shadow state and returns its result
    function automatic result_t execute_item(input logic kind, input item_t it);
        result_t     r;
        logic [16:0] pc;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] y;
        logic [31:0] imm32;
        logic [31:0] res;
        logic        stall;
        logic        alu;
        r = '0;
        if (int'(it.core) < CORES_N) begin
            pc = pc_of[it.core];
            r.next_pc = pc;
            if (kind == KIND_LOAD) begin
                if (it.first_reg != 5'd0) begin
                    gpr[{it.core, it.first_reg}] = it.load_data;
                    r.wrote = 1'b1;
                    r.written_reg = it.first_reg;
                    r.written_value = it.load_data;
                end
                busy[{it.core, it.first_reg}] = 1'b0;
            end else begin
                stall = 1'b0;
                if (it.opcode <= OP_SLT) begin
                    stall = busy[{it.core, it.first_reg}] | busy[{it.core, it.second_reg}]
                          | (!it.use_immediate && busy[{it.core, it.third_reg}]);
                end else if (it.opcode == OP_ADDI || it.opcode == OP_LW
                             || it.opcode == OP_SW) begin
                    stall = busy[{it.core, it.first_reg}] | busy[{it.core, it.second_reg}];
                end else if (it.opcode == OP_BEQ || it.opcode == OP_BNE) begin
                    stall = busy[{it.core, it.first_reg}]
                          | (!it.use_immediate && busy[{it.core, it.second_reg}]);
                end
                if (stall) begin
                    r.stalled = 1'b1;
                end else begin
                    imm32 = {{14{it.immediate[17]}}, it.immediate};
                    a = gpr[{it.core, it.second_reg}];
                    b = it.use_immediate ? imm32 : gpr[{it.core, it.third_reg}];
                    res = '0;
                    alu = 1'b0;
                    pc = pc + 17'd1;
                    case (it.opcode)
                        OP_ADD: begin
                            res = a + b;
                            alu = 1'b1;
                        end
                        OP_SUB: begin
                            res = a - b;
                            alu = 1'b1;
                        end
                        OP_MUL: begin
                            res = a * b;
                            alu = 1'b1;
                        end
                        OP_SLT: begin
                            res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                            alu = 1'b1;
                        end
                        OP_ADDI: begin
                            // immediate regardless of use_immediate
                            res = a + imm32;
                            alu = 1'b1;
                        end
                        OP_BEQ, OP_BNE: begin
                            y = it.use_immediate ? imm32 : a;
                            if ((it.opcode == OP_BEQ) == (gpr[{it.core, it.first_reg}] == y)) begin
                                pc = it.target;
                            end
                        end
                        OP_J: begin
                            pc = it.target;
                        end
                        OP_LW: begin
                            r.mem_request = MEM_READ;
                            r.mem_address = imm32 + a;
                            busy[{it.core, it.first_reg}] = 1'b1;
                        end
                        OP_SW: begin
                            r.mem_request = MEM_WRITE;
                            r.mem_address = imm32 + a;
                            r.store_data = gpr[{it.core, it.first_reg}];
                        end
                        default: begin
                        end
                    endcase
                    if (alu && it.first_reg != 5'd0) begin
                        gpr[{it.core, it.first_reg}] = res;
                        r.wrote = 1'b1;
                        r.written_reg = it.first_reg;
                        r.written_value = res;
                    end
                    pc_of[it.core] = pc;
                    r.next_pc = pc;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", n_results, what, got, want);
        errors++;
    endtask

    task automatic compare_result(input result_t got, input result_t want);
        if (got.stalled !== want.stalled)
            report_mismatch("stalled", 32'(got.stalled), 32'(want.stalled));
        if (got.next_pc !== want.next_pc)
            report_mismatch("next_pc", 32'(got.next_pc), 32'(want.next_pc));
        if (got.wrote !== want.wrote)
            report_mismatch("wrote", 32'(got.wrote), 32'(want.wrote));
        if (got.written_reg !== want.written_reg)
            report_mismatch("written_reg", 32'(got.written_reg), 32'(want.written_reg));
        if (got.written_value !== want.written_value)
            report_mismatch("written_value", got.written_value, want.written_value);
        if (got.mem_request !== want.mem_request)
            report_mismatch("mem_request", 32'(got.mem_request), 32'(want.mem_request));
        if (got.mem_address !== want.mem_address)
            report_mismatch("mem_address", got.mem_address, want.mem_address);
        if (got.store_data !== want.store_data)
            report_mismatch("store_data", got.store_data, want.store_data);
    endtask

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin : monitor
        result_t got;
        result_t pred;
        cycles++;
        if (cycles > LIMIT) begin
            $display("[mips_subset_execute_with_scoreboard] ERROR");
            $finish;
        end else if (aresetn) begin
            // retire the older result before taking in the new item
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing expected", 32'd0, 32'd0);
                end else begin
                    compare_result(got, pending_results.pop_front());
                end
                n_results++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pred = execute_item(items[n_accepted].kind, items[n_accepted].it);
                pending_results.insert(pending_results.size(),
                                       items[n_accepted].exact ? items[n_accepted].want
                                                               : pred);
                n_accepted++;
            end
        end
    end

    initial begin
        stim_t      s;
        logic [6:0] open_loads[$];
        int         roll;
        int         k;
        int         total;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        foreach (gpr[k]) begin
            gpr[k] = '0;
            busy[k] = 1'b0;
        end
        foreach (pc_of[k]) pc_of[k] = '0;

        // core 0: extremes of the immediate, every alu op, branches, jump
        dir_rows[0] = make_item(KIND_INSTR, 0, OP_ADDI, 1, 0, 0, 0, 18'h1FFFF, 0, 0);
        dir_rows[0].exact = 1'b1;
        dir_rows[0].want = make_result(0, 1, 1, 1, 32'h0001FFFF, MEM_NONE, 0, 0);
        dir_rows[1] = make_item(KIND_INSTR, 0, OP_ADDI, 2, 0, 31, 1, 18'h20000, 0, 0);
        dir_rows[1].exact = 1'b1;
        dir_rows[1].want = make_result(0, 2, 1, 2, 32'hFFFE0000, MEM_NONE, 0, 0);
        dir_rows[2] = make_item(KIND_INSTR, 0, OP_ADD, 3, 1, 2, 0, 0, 0, 0);
        dir_rows[3] = make_item(KIND_INSTR, 0, OP_SUB, 4, 2, 1, 0, 0, 0, 0);
        dir_rows[4] = make_item(KIND_INSTR, 0, OP_MUL, 5, 2, 2, 0, 0, 0, 0);
        dir_rows[5] = make_item(KIND_INSTR, 0, OP_SLT, 6, 2, 1, 0, 0, 0, 0);
        dir_rows[6] = make_item(KIND_INSTR, 0, OP_SLT, 7, 1, 0, 1, 18'h3FFFF, 0, 0);
        // write to register zero is dropped
        dir_rows[7] = make_item(KIND_INSTR, 0, OP_ADDI, 0, 1, 0, 0, 18'd5, 0, 0);
        dir_rows[8] = make_item(KIND_INSTR, 0, OP_BEQ, 1, 1, 0, 0, 0, 17'h1FFFF, 0);
        dir_rows[9] = make_item(KIND_INSTR, 0, OP_BNE, 1, 2, 0, 0, 0, 17'h0, 0);
        dir_rows[10] = make_item(KIND_INSTR, 0, OP_BEQ, 1, 0, 0, 1, 18'h0, 17'h0AAAA, 0);
        dir_rows[11] = make_item(KIND_INSTR, 0, OP_J, 0, 0, 0, 0, 0, 17'h00155, 0);
        // load, then hazards on its register, then its return
        dir_rows[12] = make_item(KIND_INSTR, 0, OP_LW, 8, 1, 0, 0, 18'h3FFFF, 0, 0);
        dir_rows[13] = make_item(KIND_INSTR, 0, OP_ADD, 9, 8, 1, 0, 0, 0, 0);
        dir_rows[14] = make_item(KIND_INSTR, 0, OP_SW, 8, 2, 0, 0, 0, 0, 0);
        dir_rows[15] = make_item(KIND_INSTR, 0, OP_J, 0, 0, 0, 0, 0, 17'h1FFFF, 0);
        dir_rows[16] = make_item(KIND_LOAD, 0, OP_ADD, 8, 0, 0, 0, 0, 0, 32'h80000000);
        dir_rows[17] = make_item(KIND_INSTR, 0, OP_SW, 8, 2, 0, 0, 18'h1FFFF, 0, 0);
        // label and unused opcode just step the pc
        dir_rows[18] = make_item(KIND_INSTR, 1, OP_LABEL, 31, 31, 31, 1, 18'h3FFFF,
                                 17'h1FFFF, 32'hFFFFFFFF);
        dir_rows[18].exact = 1'b1;
        dir_rows[18].want = make_result(0, 1, 0, 0, 0, MEM_NONE, 0, 0);
        dir_rows[19] = make_item(KIND_INSTR, 2, OP_UNUSED_TOP, 0, 0, 0, 0, 0, 0, 0);
        dir_rows[19].exact = 1'b1;
        dir_rows[19].want = make_result(0, 1, 0, 0, 0, MEM_NONE, 0, 0);
        // load into register zero still marks it pending
        dir_rows[20] = make_item(KIND_INSTR, 3, OP_LW, 0, 0, 0, 0, 0, 0, 0);
        dir_rows[20].exact = 1'b1;
        dir_rows[20].want = make_result(0, 1, 0, 0, 0, MEM_READ, 0, 0);
        dir_rows[21] = make_item(KIND_INSTR, 3, OP_ADD, 1, 0, 0, 0, 0, 0, 0);
        dir_rows[21].exact = 1'b1;
        dir_rows[21].want = make_result(1, 1, 0, 0, 0, MEM_NONE, 0, 0);
        dir_rows[22] = make_item(KIND_LOAD, 3, OP_ADD, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF);
        dir_rows[22].exact = 1'b1;
        dir_rows[22].want = make_result(0, 1, 0, 0, 0, MEM_NONE, 0, 0);
        // load return with no load outstanding
        dir_rows[23] = make_item(KIND_LOAD, 2, OP_ADD, 31, 0, 0, 0, 0, 0, 32'h7FFFFFFF);
        dir_rows[23].exact = 1'b1;
        dir_rows[23].want = make_result(0, 1, 1, 31, 32'h7FFFFFFF, MEM_NONE, 0, 0);
        dir_rows[24] = make_item(KIND_INSTR, 3, OP_ADD, 31, 0, 0, 0, 0, 0, 0);
        foreach (dir_rows[k]) items.insert(items.size(), dir_rows[k]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(99);
            s = make_item(KIND_INSTR, 2'($urandom_range(3)),
                          ($urandom_range(9) == 0) ? 4'($urandom_range(OP_UNUSED_TOP))
                                                   : 4'($urandom_range(OP_LABEL)),
                          pick_reg(), pick_reg(), pick_reg(), 1'($urandom_range(1)),
                          18'($urandom), 17'($urandom), $urandom);
            if (open_loads.size() > 6 || (roll < 15 && open_loads.size() > 0)) begin
                k = $urandom_range(open_loads.size() - 1);
                s.kind = KIND_LOAD;
                s.it.core = open_loads[k][6:5];
                s.it.first_reg = open_loads[k][4:0];
                open_loads.delete(k);
            end else if (roll < 20) begin
                s.kind = KIND_LOAD;
            end else if (s.it.opcode == OP_LW) begin
                open_loads.insert(open_loads.size(), {s.it.core, s.it.first_reg});
            end
            items.insert(items.size(), s);
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        total = items.size();
        for (int i = 0; i < total; i++) begin
            if (i < total / 3) begin
                send_idle = 25;
                recv_idle = 51;
            end else if (i < 2 * total / 3) begin
                send_idle = 51;
                recv_idle = 25;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            while ($urandom_range(99) < send_idle) begin
                s_axis_tvalid <= 1'b0;
                @(negedge aclk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= items[i].it;
            s_axis_tuser <= items[i].kind;
            do @(negedge aclk); while (n_accepted <= i);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (errors == 0) begin
            $display("[mips_subset_execute_with_scoreboard] OK");
        end else begin
            $display("[mips_subset_execute_with_scoreboard] ERROR");
        end
        $finish;
    end

endmodule
